// File: sv/ico_idx_pkg.sv
// ----------------------------------------------------------------------------
// Icosphere index generator package
// Shared widths, codes and constants for the index generator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ico_idx_pkg;

    localparam int IDX_W      = 16;
    localparam int SUB_W      = 6;
    localparam int STRIP_W    = 3;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int S1_W       = 7;
    localparam int RLEN_W     = 8;
    localparam int PLEN_W     = 14;
    localparam int ROWBASE_W  = 13;
    localparam int COLBASE_W  = 14;

    localparam logic [STRIP_W-1:0] STRIP_LAST = 3'd4;

    typedef enum logic [1:0] {
        PH_BODY   = 2'd0,
        PH_SEAM_A = 2'd1,
        PH_SEAM_B = 2'd2,
        PH_SEAM_C = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// File: sv/icosphere_index_generator_unit.sv
// ----------------------------------------------------------------------------
// Icosphere index generator
// Emits one quad (two triangles) of the icosphere triangle list per
// transaction, strip by strip: body rows, then three seam passes.
// ----------------------------------------------------------------------------
// An accepted transaction's result is in the output register the next cycle.
// 1 quad/cycle unless stalled; strip, row and column bases are running sums.
// Output register stall propagates straight back to the input side.
// Reset (synchronous, active low): subdivision 0, position at first quad,
// output empty. A subdivision write also returns to the first quad.
`default_nettype none

module icosphere_index_generator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [ico_idx_pkg::SUB_W-1:0]       i_cfg_wr_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_restart,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri1_a,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri1_b,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri1_c,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri2_a,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri2_b,
    output logic [ico_idx_pkg::IDX_W-1:0]            o_tri2_c,
    output logic                                     o_last_quad
);

    // configuration-derived lengths
    logic [ico_idx_pkg::SUB_W-1:0]     r_s;
    logic [ico_idx_pkg::S1_W-1:0]      r_s1;
    logic [ico_idx_pkg::RLEN_W-1:0]    r_r;
    logic [ico_idx_pkg::PLEN_W-1:0]    r_p;
    logic [ico_idx_pkg::IDX_W-1:0]     r_v;

    // position
    logic [ico_idx_pkg::STRIP_W-1:0]   r_strip, e_strip, n_strip;
    ico_idx_pkg::t_phase               r_phase, e_phase, n_phase;
    logic [ico_idx_pkg::ROW_W-1:0]     r_row, e_row, n_row;
    logic [ico_idx_pkg::COL_W-1:0]     r_col, e_col, n_col;
    logic [ico_idx_pkg::IDX_W-1:0]     r_strip_base, e_strip_base, n_strip_base;
    logic [ico_idx_pkg::ROWBASE_W-1:0] r_row_base, e_row_base, n_row_base;
    logic [ico_idx_pkg::COLBASE_W-1:0] r_col_base, e_col_base, n_col_base;

    // config write datapath
    logic [ico_idx_pkg::S1_W-1:0]      cfg_s1;
    logic [2*ico_idx_pkg::S1_W-1:0]    cfg_sq_full;
    logic [12:0]                       cfg_sq;
    logic [ico_idx_pkg::IDX_W-1:0]     cfg_v;

    // index datapath
    logic [ico_idx_pkg::IDX_W-1:0]     k16, s1_16, r16, p16, kr16, rb16;
    logic [ico_idx_pkg::IDX_W-1:0]     sp1, nb, f, a, b, c, d;
    logic [ico_idx_pkg::IDX_W-1:0]     t0, t1, t2, t3, t4, t5;
    logic                              last;
    logic [ico_idx_pkg::COL_W-1:0]     col1;
    logic [ico_idx_pkg::ROW_W-1:0]     row1;
    logic                              in_accept;

    logic                              r_out_valid;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = !i_rst_n || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    assign cfg_s1      = {1'b0, i_cfg_wr_data} + 7'd1;
    assign cfg_sq_full = cfg_s1 * cfg_s1;
    assign cfg_sq      = cfg_sq_full[12:0];
    assign cfg_v       = ({3'b0, cfg_sq} << 3) + ({3'b0, cfg_sq} << 1) + 16'd2;

    always_comb begin
        // restart, then skip passes that are empty at zero subdivision
        if (i_restart) begin
            e_strip      = '0;
            e_phase      = ico_idx_pkg::PH_BODY;
            e_row        = '0;
            e_col        = '0;
            e_strip_base = '0;
            e_row_base   = '0;
            e_col_base   = '0;
        end else begin
            e_strip      = r_strip;
            e_phase      = r_phase;
            e_row        = r_row;
            e_col        = r_col;
            e_strip_base = r_strip_base;
            e_row_base   = r_row_base;
            e_col_base   = r_col_base;
        end
        if (r_s == '0) begin
            if (e_phase == ico_idx_pkg::PH_BODY) begin
                e_phase    = ico_idx_pkg::PH_SEAM_A;
                e_row      = '0;
                e_col      = '0;
                e_row_base = '0;
                e_col_base = '0;
            end else if (e_phase == ico_idx_pkg::PH_SEAM_B) begin
                e_phase    = ico_idx_pkg::PH_SEAM_C;
                e_col      = '0;
                e_col_base = '0;
            end
        end

        k16   = {9'b0, e_col};
        s1_16 = {9'b0, r_s1};
        r16   = {8'b0, r_r};
        p16   = {2'b0, r_p};
        kr16  = {2'b0, e_col_base};
        rb16  = {3'b0, e_row_base};
        sp1   = e_strip_base + p16;
        nb    = (e_strip == ico_idx_pkg::STRIP_LAST) ? '0 : sp1;

        f = k16 + rb16 + e_strip_base + 16'd1;
        a = '0;
        b = '0;
        c = '0;
        d = '0;
        case (e_phase)
            ico_idx_pkg::PH_SEAM_A: begin
                a = k16 + sp1 - r16 + 16'd1;
                b = (p16 - kr16) + nb + 16'd1;
                c = b - r16;
                d = a + 16'd1;
                if (e_col == '0) b = '0;
            end
            ico_idx_pkg::PH_SEAM_B: begin
                a = s1_16 + k16 + sp1 - r16 + 16'd1;
                b = k16 + nb + 16'd1;
                c = b + 16'd1;
                d = a + 16'd1;
            end
            ico_idx_pkg::PH_SEAM_C: begin
                a = kr16 + r16 + e_strip_base;
                b = a + r16;
                c = r16 - k16 + nb;
                d = c + 16'd1;
                if (e_col == {1'b0, r_s}) b = c - 16'd1;
                if (e_col == '0) d = r_v - 16'd1;
            end
            default: begin
            end
        endcase

        if (e_phase == ico_idx_pkg::PH_BODY) begin
            t0 = f;
            t1 = f + 16'd1;
            t2 = f + r16 + 16'd1;
            t3 = f;
            t4 = f + r16 + 16'd1;
            t5 = f + r16;
        end else begin
            t0 = a;
            t1 = d;
            t2 = c;
            t3 = a;
            t4 = c;
            t5 = b;
        end

        // advance to the next quad
        col1         = e_col + 7'd1;
        row1         = e_row + 6'd1;
        last         = 1'b0;
        n_strip      = e_strip;
        n_phase      = e_phase;
        n_row        = e_row;
        n_col        = col1;
        n_strip_base = e_strip_base;
        n_row_base   = e_row_base;
        n_col_base   = e_col_base + {6'b0, r_r};
        case (e_phase)
            ico_idx_pkg::PH_BODY: begin
                if (col1 >= {r_s, 1'b1}) begin
                    n_col      = '0;
                    n_col_base = '0;
                    n_row      = row1;
                    n_row_base = e_row_base + {5'b0, r_r};
                    if (row1 >= r_s) begin
                        n_row      = '0;
                        n_row_base = '0;
                        n_phase    = ico_idx_pkg::PH_SEAM_A;
                    end
                end
            end
            ico_idx_pkg::PH_SEAM_A: begin
                if (col1 >= r_s1) begin
                    n_col      = '0;
                    n_col_base = '0;
                    n_phase    = ico_idx_pkg::PH_SEAM_B;
                end
            end
            ico_idx_pkg::PH_SEAM_B: begin
                if (col1 >= {1'b0, r_s}) begin
                    n_col      = '0;
                    n_col_base = '0;
                    n_phase    = ico_idx_pkg::PH_SEAM_C;
                end
            end
            default: begin
                if (col1 >= r_s1) begin
                    n_col      = '0;
                    n_col_base = '0;
                    n_row      = '0;
                    n_row_base = '0;
                    n_phase    = ico_idx_pkg::PH_BODY;
                    if (e_strip >= ico_idx_pkg::STRIP_LAST) begin
                        n_strip      = '0;
                        n_strip_base = '0;
                        last         = 1'b1;
                    end else begin
                        n_strip      = e_strip + 3'd1;
                        n_strip_base = sp1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s          <= '0;
            r_s1         <= 7'd1;
            r_r          <= 8'd2;
            r_p          <= 14'd2;
            r_v          <= 16'd12;
            r_strip      <= '0;
            r_phase      <= ico_idx_pkg::PH_BODY;
            r_row        <= '0;
            r_col        <= '0;
            r_strip_base <= '0;
            r_row_base   <= '0;
            r_col_base   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_s          <= i_cfg_wr_data;
                r_s1         <= cfg_s1;
                r_r          <= {cfg_s1, 1'b0};
                r_p          <= {cfg_sq, 1'b0};
                r_v          <= cfg_v;
                r_strip      <= '0;
                r_phase      <= ico_idx_pkg::PH_BODY;
                r_row        <= '0;
                r_col        <= '0;
                r_strip_base <= '0;
                r_row_base   <= '0;
                r_col_base   <= '0;
            end else if (in_accept) begin
                r_strip      <= n_strip;
                r_phase      <= n_phase;
                r_row        <= n_row;
                r_col        <= n_col;
                r_strip_base <= n_strip_base;
                r_row_base   <= n_row_base;
                r_col_base   <= n_col_base;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            o_tri1_a    <= t0;
            o_tri1_b    <= t1;
            o_tri1_c    <= t2;
            o_tri2_a    <= t3;
            o_tri2_b    <= t4;
            o_tri2_c    <= t5;
            o_last_quad <= last;
        end
    end

endmodule

`default_nettype wire

// File: sv/ico_idx_checker.sv
// ----------------------------------------------------------------------------
// Icosphere index generator checker
// Port-level assertions on handshake, reset and quad shape.
// ----------------------------------------------------------------------------
`default_nettype none

module ico_idx_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri1_a,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri1_b,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri1_c,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri2_a,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri2_b,
    input wire logic [ico_idx_pkg::IDX_W-1:0]  o_tri2_c,
    input wire logic                           o_last_quad
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tri1_a)
            && $stable(o_tri1_b) && $stable(o_tri1_c) && $stable(o_tri2_a)
            && $stable(o_tri2_b) && $stable(o_tri2_c) && $stable(o_last_quad))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // both triangles share the quad diagonal
    a_shared_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_tri1_a == o_tri2_a && o_tri1_c == o_tri2_b)
        else $error("triangles do not share the diagonal");

endmodule

bind icosphere_index_generator_unit ico_idx_checker u_ico_idx_checker (.*);

`default_nettype wire

// File: bench/icosphere_index_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Icosphere index generator testbench
// Streams restart/continue transactions into the generator with bursty input
// and patterned output stall. A local model of the quad walk predicts every
// result, and each output transaction is checked field by field.
// Subdivisions 0 to 4 and 63 are loaded, and short sets run through full spheres.
// ----------------------------------------------------------------------------

module icosphere_index_generator_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [ico_idx_pkg::IDX_W-1:0] tri1_a;
        logic [ico_idx_pkg::IDX_W-1:0] tri1_b;
        logic [ico_idx_pkg::IDX_W-1:0] tri1_c;
        logic [ico_idx_pkg::IDX_W-1:0] tri2_a;
        logic [ico_idx_pkg::IDX_W-1:0] tri2_b;
        logic [ico_idx_pkg::IDX_W-1:0] tri2_c;
        logic                          last_quad;
    } t_quad;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ico_idx_pkg::SUB_W-1:0] cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          restart = 1'b0;
    logic                          out_stall = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic [ico_idx_pkg::IDX_W-1:0] tri1_a, tri1_b, tri1_c, tri2_a, tri2_b, tri2_c;
    logic                          last_quad;

    icosphere_index_generator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_restart     (restart),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_tri1_a      (tri1_a),
        .o_tri1_b      (tri1_b),
        .o_tri1_c      (tri1_c),
        .o_tri2_a      (tri2_a),
        .o_tri2_b      (tri2_b),
        .o_tri2_c      (tri2_c),
        .o_last_quad   (last_quad)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model state
    logic [ico_idx_pkg::SUB_W-1:0]   mdl_sub = '0;
    logic [ico_idx_pkg::STRIP_W-1:0] pos_strip = '0;
    ico_idx_pkg::t_phase             pos_phase = ico_idx_pkg::PH_BODY;
    logic [ico_idx_pkg::ROW_W-1:0]   pos_row = '0;
    logic [ico_idx_pkg::COL_W-1:0]   pos_col = '0;

    logic  pending_restarts[$];
    t_quad expected_quads[$];
    int    err_count = 0;

    function automatic void rewind_position();
        pos_strip = '0;
        pos_phase = ico_idx_pkg::PH_BODY;
        pos_row   = '0;
        pos_col   = '0;
    endfunction

    function automatic void skip_empty_passes();
        if (pos_phase == ico_idx_pkg::PH_BODY && mdl_sub == 0) begin
            pos_phase = ico_idx_pkg::PH_SEAM_A;
            pos_row   = '0;
            pos_col   = '0;
        end
        if (pos_phase == ico_idx_pkg::PH_SEAM_B && mdl_sub == 0) begin
            pos_phase = ico_idx_pkg::PH_SEAM_C;
            pos_col   = '0;
        end
    endfunction

    function automatic t_quad next_quad(input logic rst_seq);
        int unsigned s, sp1, rlen, plen, nverts, i, n, k, a, b, c, d, f;
        int unsigned t[6];
        t_quad q;
        s      = mdl_sub;
        sp1    = s + 1;
        rlen   = 2 * sp1;
        plen   = rlen * sp1;
        nverts = 10 * sp1 * sp1 + 2;
        if (rst_seq)
            rewind_position();
        skip_empty_passes();
        i = pos_strip;
        n = (i + 1) % 5;
        k = pos_col;
        if (pos_phase == ico_idx_pkg::PH_BODY) begin
            f = k + rlen * pos_row + plen * i + 1;
            t[0] = f;
            t[1] = f + 1;
            t[2] = f + rlen + 1;
            t[3] = f;
            t[4] = f + rlen + 1;
            t[5] = f + rlen;
        end else begin
            if (pos_phase == ico_idx_pkg::PH_SEAM_A) begin
                a = k + plen * (i + 1) - rlen + 1;
                b = (sp1 - k) * rlen + plen * n + 1;
                c = b - rlen;
                d = a + 1;
                if (k == 0)
                    b = 0;
            end else if (pos_phase == ico_idx_pkg::PH_SEAM_B) begin
                a = sp1 + k + plen * (i + 1) - rlen + 1;
                b = k + plen * n + 1;
                c = b + 1;
                d = a + 1;
            end else begin
                a = rlen * (k + 1) + plen * i;
                b = a + rlen;
                c = rlen - k + plen * n;
                d = c + 1;
                if (k == s)
                    b = c - 1;
                if (k == 0)
                    d = nverts - 1;
            end
            t[0] = a;
            t[1] = d;
            t[2] = c;
            t[3] = a;
            t[4] = c;
            t[5] = b;
        end
        q.last_quad = 1'b0;
        pos_col = pos_col + 1'b1;
        case (pos_phase)
            ico_idx_pkg::PH_BODY: begin
                if (pos_col >= 2 * s + 1) begin
                    pos_col = '0;
                    pos_row = pos_row + 1'b1;
                    if (pos_row >= s) begin
                        pos_row   = '0;
                        pos_phase = ico_idx_pkg::PH_SEAM_A;
                    end
                end
            end
            ico_idx_pkg::PH_SEAM_A: begin
                if (pos_col >= sp1) begin
                    pos_col   = '0;
                    pos_phase = ico_idx_pkg::PH_SEAM_B;
                end
            end
            ico_idx_pkg::PH_SEAM_B: begin
                if (pos_col >= s) begin
                    pos_col   = '0;
                    pos_phase = ico_idx_pkg::PH_SEAM_C;
                end
            end
            default: begin
                if (pos_col >= sp1) begin
                    pos_col   = '0;
                    pos_row   = '0;
                    pos_phase = ico_idx_pkg::PH_BODY;
                    if (pos_strip >= ico_idx_pkg::STRIP_LAST) begin
                        pos_strip   = '0;
                        q.last_quad = 1'b1;
                    end else begin
                        pos_strip = pos_strip + 1'b1;
                    end
                end
            end
        endcase
        skip_empty_passes();
        q.tri1_a = 16'(t[0]);
        q.tri1_b = 16'(t[1]);
        q.tri1_c = 16'(t[2]);
        q.tri2_a = 16'(t[3]);
        q.tri2_b = 16'(t[4]);
        q.tri2_c = 16'(t[5]);
        return q;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall)
                expected_quads.push_back(next_quad(restart));
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_restarts.size() != 0) begin
                    in_valid <= 1'b1;
                    restart  <= pending_restarts.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, stall pattern and watchdog
    int stall_mode = 0;
    int mode_cycles = 0;
    int idle_cycles = 0;

    task automatic check_field(input string name,
                               input logic [ico_idx_pkg::IDX_W-1:0] exp_v,
                               input logic [ico_idx_pkg::IDX_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_quad exp_q;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_quads.size() == 0) begin
                    $error("output transaction with no expected quad");
                    err_count++;
                end else begin
                    exp_q = expected_quads.pop_front();
                    check_field("tri1_a", exp_q.tri1_a, tri1_a);
                    check_field("tri1_b", exp_q.tri1_b, tri1_b);
                    check_field("tri1_c", exp_q.tri1_c, tri1_c);
                    check_field("tri2_a", exp_q.tri2_a, tri2_a);
                    check_field("tri2_b", exp_q.tri2_b, tri2_b);
                    check_field("tri2_c", exp_q.tri2_c, tri2_c);
                    check_field("last_quad", 16'(exp_q.last_quad), 16'(last_quad));
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(20, 80);
            end else begin
                mode_cycles = mode_cycles - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // sampled mid-cycle so the edge's updates have all settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_restarts.size() != 0 || in_valid || out_valid
               || expected_quads.size() != 0)
            @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_subdivision(input logic [ico_idx_pkg::SUB_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        mdl_sub = value;
        rewind_position();
    endtask

    int unsigned sub_plan[12] = '{1, 2, 3, 63, 0, 4, 2, 1, 3, 63, 0, 2};

    initial begin
        int unsigned cnt, s;
        int          restart_pct;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero subdivision from reset: full sphere, wrap, restart mid sphere
        pending_restarts.push_back(1'b1);
        repeat (12) pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b1);
        pending_restarts.push_back(1'b0);

        load_subdivision(6'd63);
        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b1);
        pending_restarts.push_back(1'b0);
        pending_restarts.push_back(1'b0);

        for (int p = 0; p < 12; p++) begin
            s = sub_plan[p];
            load_subdivision(ico_idx_pkg::SUB_W'(s));
            cnt = 10 * (s + 1) * (s + 1) + $urandom_range(10, 40);
            if (cnt < 40)
                cnt = 40;
            if (s == 63)
                cnt = 50;
            restart_pct = (p % 2 == 0) ? 0 : 4;
            for (int j = 0; j < cnt; j++)
                pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
        end

        wait_drained();
        repeat (2) @(posedge i_clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
sv/ico_idx_pkg.sv
sv/icosphere_index_generator_unit.sv
sv/ico_idx_checker.sv
bench/icosphere_index_generator_unit_tb.sv
